// ----- sv/tlsm_pkg.sv -----
// Shared constants, request codes and control types of the two-list selection merge unit.
`default_nettype none

package tlsm_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int DATA_W         = 32;
    localparam int REQ_W          = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_RUN    = 2'd2
    } t_req;

    typedef struct packed {
        logic clear;
        logic sample_vld;
        logic sample_b;
    } t_scan_ctl;

endpackage

`default_nettype wire

// ----- sv/tlsm_list_mem.sv -----
// Storage for both lists: one write port, one registered read port.
`default_nettype none

module tlsm_list_mem #(
    parameter int ADDR_W = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [ADDR_W-1:0]           i_wr_addr,
    input  wire logic [tlsm_pkg::DATA_W-1:0] i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [ADDR_W-1:0]           i_rd_addr,
    output logic      [tlsm_pkg::DATA_W-1:0] o_rd_data
);
    import tlsm_pkg::*;

    localparam int ENTRIES = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [0:ENTRIES-1];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/tlsm_min_unit.sv -----
// Shared signed compare unit that keeps the smallest sample seen in the current scan.
`default_nettype none

module tlsm_min_unit #(
    parameter int IDX_W = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tlsm_pkg::t_scan_ctl         i_ctl,
    input  wire logic [IDX_W-1:0]            i_sample_idx,
    input  wire logic [tlsm_pkg::DATA_W-1:0] i_sample_data,
    output logic                             o_best_vld,
    output logic                             o_best_b,
    output logic      [IDX_W-1:0]            o_best_idx,
    output logic      [tlsm_pkg::DATA_W-1:0] o_best_data
);
    import tlsm_pkg::*;

    logic              r_best_vld;
    logic              r_best_b;
    logic [IDX_W-1:0]  r_best_idx;
    logic [DATA_W-1:0] r_best_data;
    logic              w_take;

    // Strictly smaller replaces, so the earliest scanned entry wins a tie.
    assign w_take = i_ctl.sample_vld &&
                    (!r_best_vld || ($signed(i_sample_data) < $signed(r_best_data)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_best_vld <= 1'b0;
        end else if (w_take) begin
            r_best_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.clear && w_take) begin
            r_best_b    <= i_ctl.sample_b;
            r_best_idx  <= i_sample_idx;
            r_best_data <= i_sample_data;
        end
    end

    assign o_best_vld  = r_best_vld;
    assign o_best_b    = r_best_b;
    assign o_best_idx  = r_best_idx;
    assign o_best_data = r_best_data;

endmodule

`default_nettype wire

// ----- sv/two_list_selection_merge_unit.sv -----
// Top level of the two-list selection merge unit: sequencer, counts, used flags, output register.
// A load transfer gives no result.
// A run gives count_a + count_b results; each is found by one memory read per stored
// entry through the single read port, then the compare drain state and the emit state.
// Reset (synchronous, active low) empties both lists, clears the used flags and the
// output register; the list storage itself is not cleared.
`default_nettype none

module two_list_selection_merge_unit #(
    parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Slave side
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic signed [tlsm_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] value
    input  wire logic        [tlsm_pkg::REQ_W-1:0]  s_axis_tuser,  // [1:0] req_type
    // Master side
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic signed      [tlsm_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] value_out
    output logic                                    m_axis_tuser,  // [0] from_b
    output logic                                    m_axis_tlast   // last result of a run
);
    import tlsm_pkg::*;

    // Index into one list, count of one list (0..LIST_DEPTH), results left in a run.
    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int LEFT_W = CNT_W + 1;
    localparam int ADDR_W = IDX_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt_a;
    logic [CNT_W-1:0]    r_cnt_b;
    logic [LIST_DEPTH-1:0] r_used_a;
    logic [LIST_DEPTH-1:0] r_used_b;
    logic [LEFT_W-1:0]   r_left;
    logic                r_scan_b;
    logic [IDX_W-1:0]    r_scan_idx;
    logic                r_rd_vld;
    logic                r_rd_b;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_out_vld;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_out_b;
    logic                r_out_last;

    logic                w_in_xfer;
    logic                w_out_free;
    logic                w_room_a;
    logic                w_room_b;
    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [LEFT_W-1:0]   w_total;
    logic                w_end_a;
    logic                w_end_b;
    logic                w_emit;
    logic                w_start_scan;
    logic                w_sample_used;
    logic [DATA_W-1:0]   w_rd_data;
    t_scan_ctl           w_ctl;
    logic                w_best_vld;
    logic                w_best_b;
    logic [IDX_W-1:0]    w_best_idx;
    logic [DATA_W-1:0]   w_best_data;

    // The block only takes transfers while no run is in progress.
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_vld || m_axis_tready;

    assign w_room_a  = (r_cnt_a < CNT_W'(LIST_DEPTH));
    assign w_room_b  = (r_cnt_b < CNT_W'(LIST_DEPTH));
    assign w_total   = LEFT_W'(r_cnt_a) + LEFT_W'(r_cnt_b);

    // Loads into a full list are dropped silently.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = {1'b0, r_cnt_a[IDX_W-1:0]};
        if (w_in_xfer) begin
            case (t_req'(s_axis_tuser))
                REQ_LOAD_A: begin
                    w_wr_en   = w_room_a;
                    w_wr_addr = {1'b0, r_cnt_a[IDX_W-1:0]};
                end
                REQ_LOAD_B: begin
                    w_wr_en   = w_room_b;
                    w_wr_addr = {1'b1, r_cnt_b[IDX_W-1:0]};
                end
                default: begin
                    w_wr_en = 1'b0;
                end
            endcase
        end
    end

    // The scan walks list A from index 0, then list B from index 0.
    assign w_end_a = (CNT_W'(r_scan_idx) + CNT_W'(1)) == r_cnt_a;
    assign w_end_b = (CNT_W'(r_scan_idx) + CNT_W'(1)) == r_cnt_b;

    assign w_emit       = (r_state == S_EMIT) && w_out_free;
    assign w_start_scan = (w_in_xfer && (t_req'(s_axis_tuser) == REQ_RUN) && (w_total != '0))
                       || (w_emit && (r_left != LEFT_W'(1)));

    // An entry already emitted in this run is not offered to the compare unit.
    assign w_sample_used = r_rd_b ? r_used_b[r_rd_idx] : r_used_a[r_rd_idx];

    assign w_ctl.clear      = w_start_scan;
    assign w_ctl.sample_vld = r_rd_vld && !w_sample_used;
    assign w_ctl.sample_b   = r_rd_b;

    tlsm_list_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (r_state == S_SCAN),
        .i_rd_addr ({r_scan_b, r_scan_idx}),
        .o_rd_data (w_rd_data)
    );

    tlsm_min_unit #(
        .IDX_W (IDX_W)
    ) u_min (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_sample_idx  (r_rd_idx),
        .i_sample_data (w_rd_data),
        .o_best_vld    (w_best_vld),
        .o_best_b      (w_best_b),
        .o_best_idx    (w_best_idx),
        .o_best_data   (w_best_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_used_a  <= '0;
            r_used_b  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN);
            r_rd_b   <= r_scan_b;
            r_rd_idx <= r_scan_idx;
            // The output register empties on a taken transfer unless a new result refills it.
            if (m_axis_tready && !w_emit) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        case (t_req'(s_axis_tuser))
                            REQ_LOAD_A: begin
                                if (w_room_a) begin
                                    r_cnt_a <= r_cnt_a + CNT_W'(1);
                                end
                            end
                            REQ_LOAD_B: begin
                                if (w_room_b) begin
                                    r_cnt_b <= r_cnt_b + CNT_W'(1);
                                end
                            end
                            REQ_RUN: begin
                                // A run with both lists empty changes nothing.
                                if (w_total != '0) begin
                                    r_left     <= w_total;
                                    r_used_a   <= '0;
                                    r_used_b   <= '0;
                                    r_scan_b   <= (r_cnt_a == '0);
                                    r_scan_idx <= '0;
                                    r_state    <= S_SCAN;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!r_scan_b) begin
                        if (w_end_a) begin
                            if (r_cnt_b != '0) begin
                                r_scan_b   <= 1'b1;
                                r_scan_idx <= '0;
                            end else begin
                                r_state <= S_DRAIN;
                            end
                        end else begin
                            r_scan_idx <= r_scan_idx + IDX_W'(1);
                        end
                    end else begin
                        if (w_end_b) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_scan_idx <= r_scan_idx + IDX_W'(1);
                        end
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= w_best_data;
                        r_out_b    <= w_best_b;
                        r_out_last <= (r_left == LEFT_W'(1));
                        r_left     <= r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            // Run complete: both lists are emptied.
                            r_cnt_a  <= '0;
                            r_cnt_b  <= '0;
                            r_used_a <= '0;
                            r_used_b <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            if (w_best_b) begin
                                r_used_b[w_best_idx] <= 1'b1;
                            end else begin
                                r_used_a[w_best_idx] <= 1'b1;
                            end
                            r_scan_b   <= (r_cnt_a == '0);
                            r_scan_idx <= '0;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_b;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(LIST_DEPTH)) && (r_cnt_b <= CNT_W'(LIST_DEPTH)))
        else $error("list count above depth");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ((r_left != '0) && (r_left <= w_total)))
        else $error("results left out of range during run");

    a_best_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> w_best_vld)
        else $error("no candidate found at emit");

    a_best_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |->
            !(w_best_b ? r_used_b[w_best_idx] : r_used_a[w_best_idx]))
        else $error("candidate already emitted in this run");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_left == LEFT_W'(1))) |=>
            ((r_cnt_a == '0) && (r_cnt_b == '0) && (r_state == S_IDLE)))
        else $error("lists not emptied after final result");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the two-list selection merge unit with a result scoreboard.

module testbench;

    import tlsm_pkg::*;

    localparam int LIST_DEPTH = LIST_DEPTH_DEF;
    // Request code that the block has no use for; it must be swallowed silently.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    // Final wait, worked out from the per-result bound with both lists full, then doubled.
    localparam int SETTLE_CYCLES = 2 * (2 * LIST_DEPTH + 2);
    localparam int RANDOM_ITEMS  = 40;
    localparam int TIMEOUT_UNITS = 1_000_000;
    localparam int MAX_REPORTS   = 50;

    localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     from_b;
        logic                     last;
    } t_merge_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic signed [DATA_W-1:0] s_axis_tdata = '0;  // [31:0] value
    logic        [REQ_W-1:0]  s_axis_tuser = '0;  // [1:0] req_type
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic signed [DATA_W-1:0] m_axis_tdata;       // [31:0] value_out
    logic                     m_axis_tuser;       // [0] from_b
    logic                     m_axis_tlast;

    // Shadow copy of the two lists, kept in step with every accepted load.
    logic signed [DATA_W-1:0] a_vals [LIST_DEPTH];
    logic signed [DATA_W-1:0] b_vals [LIST_DEPTH];
    bit                       a_used [LIST_DEPTH];
    bit                       b_used [LIST_DEPTH];
    int                       a_count = 0;
    int                       b_count = 0;

    t_merge_result            expected_merge_q [$];

    int  errors          = 0;
    int  results_checked = 0;
    int  runs_done       = 0;
    int  loads_dropped   = 0;
    int  items_sent      = 0;
    // While set, neither side of the stream idles.
    bit  calm            = 1'b0;

    two_list_selection_merge_unit #(
        .LIST_DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Index of the smallest entry of one list not yet emitted, or -1 when none is left.
    // A strict comparison keeps the lower index on a tie.
    function automatic int smallest_unused(bit in_b);
        int                       best;
        int                       n;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] best_v;
        best   = -1;
        best_v = '0;
        n      = in_b ? b_count : a_count;
        for (int i = 0; i < n; i++) begin
            v = in_b ? b_vals[i] : a_vals[i];
            if (!(in_b ? b_used[i] : a_used[i]) && (best < 0 || v < best_v)) begin
                best   = i;
                best_v = v;
            end
        end
        return best;
    endfunction

    // Applies one accepted request to the shadow lists; a run queues its sorted results.
    function automatic void merge_apply_request(logic [REQ_W-1:0] req,
                                                logic signed [DATA_W-1:0] val);
        int            total;
        int            pa;
        int            pb;
        t_merge_result r;
        case (req)
            REQ_LOAD_A: begin
                if (a_count < LIST_DEPTH) begin
                    a_vals[a_count] = val;
                    a_count++;
                end else begin
                    loads_dropped++;
                end
            end
            REQ_LOAD_B: begin
                if (b_count < LIST_DEPTH) begin
                    b_vals[b_count] = val;
                    b_count++;
                end else begin
                    loads_dropped++;
                end
            end
            REQ_RUN: begin
                total = a_count + b_count;
                if (total > 0) begin
                    for (int i = 0; i < LIST_DEPTH; i++) begin
                        a_used[i] = 1'b0;
                        b_used[i] = 1'b0;
                    end
                    for (int k = 0; k < total; k++) begin
                        pa = smallest_unused(1'b0);
                        pb = smallest_unused(1'b1);
                        // A tie between the two lists goes to list A.
                        if (pa >= 0 && (pb < 0 || a_vals[pa] <= b_vals[pb])) begin
                            r.value    = a_vals[pa];
                            r.from_b   = 1'b0;
                            a_used[pa] = 1'b1;
                        end else begin
                            r.value    = b_vals[pb];
                            r.from_b   = 1'b1;
                            b_used[pb] = 1'b1;
                        end
                        r.last = (k == total - 1);
                        expected_merge_q.insert(expected_merge_q.size(), r);
                    end
                    runs_done++;
                end
                a_count = 0;
                b_count = 0;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic check_result();
        t_merge_result want;
        if (expected_merge_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected result: value %0d from_b %0b last %0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
            want = expected_merge_q.pop_front();
            results_checked++;
            if (m_axis_tdata !== want.value || m_axis_tuser !== want.from_b
                    || m_axis_tlast !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: mismatch: expected value %0d from_b %0b last %0b,",
                              " got value %0d from_b %0b last %0b"},
                             $time, want.value, want.from_b, want.last,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
        end
    endtask

    // Both stream sides are observed at the same edge: requests feed the predictor
    // first, then any result transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            merge_apply_request(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
    end

    // The receiver stalls in about a quarter of the cycles unless the calm stretch is on.
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
    end

    // Drives one request and holds it until the block takes the transfer.
    // The valid line is assigned once per step, so back-to-back transfers stay high.
    task automatic send_item(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] val);
        int gap;
        if (!calm && $urandom_range(0, 99) < 25) begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= val;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    // Holds the sender back until every queued result has been seen.
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_merge_q.size() != 0) @(posedge i_clk);
    endtask

    // Small values (-4..4) in four draws of ten so that ties are common, the range ends mixed in.
    function automatic logic signed [DATA_W-1:0] random_element_value();
        case ($urandom_range(0, 9))
            0:       return MOST_NEGATIVE;
            1:       return MOST_POSITIVE;
            2, 3, 4, 5: return $urandom_range(0, 8) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Range ends in both lists, equal values inside one list and equal values across lists.
    task automatic test_extremes_and_ties();
        send_item(REQ_LOAD_A, MOST_NEGATIVE);
        send_item(REQ_LOAD_A, MOST_POSITIVE);
        send_item(REQ_LOAD_A, 0);
        send_item(REQ_LOAD_A, -1);
        send_item(REQ_LOAD_A, 7);
        send_item(REQ_LOAD_A, 7);
        send_item(REQ_LOAD_B, MOST_NEGATIVE);
        send_item(REQ_LOAD_B, MOST_POSITIVE);
        send_item(REQ_LOAD_B, 0);
        send_item(REQ_LOAD_B, 7);
        send_item(REQ_LOAD_B, 1);
        send_item(REQ_RUN, $urandom);
    endtask

    // Requests that give no result: a run on empty lists and the unused code,
    // then single-entry runs from each list alone.
    task automatic test_idle_requests();
        send_item(REQ_RUN, $urandom);
        send_item(REQ_UNUSED, $urandom);
        send_item(REQ_LOAD_A, $urandom);
        send_item(REQ_UNUSED, $urandom);
        send_item(REQ_RUN, $urandom);
        send_item(REQ_LOAD_B, $urandom);
        send_item(REQ_RUN, $urandom);
        send_item(REQ_RUN, $urandom);
        wait_all_results();
    endtask

    // Both lists are filled past their depth with no idling on either side;
    // the surplus loads must be dropped and the run gives the largest result set.
    task automatic test_list_overflow();
        int na;
        int nb;
        calm = 1'b1;
        na   = LIST_DEPTH + 2;
        nb   = LIST_DEPTH + 2;
        while (na > 0 || nb > 0) begin
            if (na > 0 && (nb == 0 || $urandom_range(0, 1) == 0)) begin
                send_item(REQ_LOAD_A, random_element_value());
                na--;
            end else begin
                send_item(REQ_LOAD_B, random_element_value());
                nb--;
            end
        end
        send_item(REQ_RUN, $urandom);
        wait_all_results();
        calm = 1'b0;
    endtask

    // Load sequences of random length and content closed by a run. Now and then a
    // sequence is left without its run, so its loads carry into the next one, and
    // unused codes are scattered in as noise.
    task automatic test_random_sequences();
        int  stop_at;
        int  na;
        int  nb;
        bit  drained;
        stop_at = items_sent + RANDOM_ITEMS;
        drained = 1'b0;
        while (items_sent < stop_at) begin
            na = ($urandom_range(0, 7) == 0) ? $urandom_range(0, LIST_DEPTH + 1)
                                             : $urandom_range(0, 6);
            nb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, LIST_DEPTH + 1)
                                             : $urandom_range(0, 6);
            while (na > 0 || nb > 0) begin
                if ($urandom_range(0, 14) == 0)
                    send_item(REQ_UNUSED, $urandom);
                if (na > 0 && (nb == 0 || $urandom_range(0, 1) == 0)) begin
                    send_item(REQ_LOAD_A, random_element_value());
                    na--;
                end else begin
                    send_item(REQ_LOAD_B, random_element_value());
                    nb--;
                end
            end
            if ($urandom_range(0, 7) != 0)
                send_item(REQ_RUN, $urandom);
            // Once, half way through, let the result side empty completely.
            if (!drained && items_sent >= stop_at - RANDOM_ITEMS / 2) begin
                wait_all_results();
                drained = 1'b1;
            end
        end
        // Close off whatever the last sequence left loaded.
        send_item(REQ_RUN, $urandom);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes_and_ties();
        test_idle_requests();
        test_list_overflow();
        test_random_sequences();
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_merge_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_merge_q.size());
        end
        $display("Sent %0d requests covering %0d merge runs; %0d results compared.",
                 items_sent, runs_done, results_checked);
        $display("Loads refused by a full list: %0d; mismatches found: %0d.",
                 loads_dropped, errors);
        if (errors == 0) begin
            $display("PASS two_list_selection_merge_unit");
        end else begin
            $display("FAIL two_list_selection_merge_unit");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("FAIL two_list_selection_merge_unit");
        $finish;
    end

endmodule
